// File: design/assert_macros.svh
// Assertion macros used by the top-level design file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is active.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is active.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/wpp_pkg.sv
// Types, codes and header tables of the WAV PCM stream parser.
package wpp_pkg;

  // One input word: a byte of the file and its end marker.
  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_of_stream;
  } wpp_in_t;

  // One result word.
  typedef struct packed {
    logic signed [15:0] sample;
    logic [1:0]         kind;
    logic [3:0]         error_code;
    logic               last;
  } wpp_out_t;

  // Results produced by one accepted byte, in order.
  typedef struct packed {
    logic [1:0] count;
    wpp_out_t   first;
    wpp_out_t   second;
  } wpp_push_t;

  // Result kinds.
  localparam logic [1:0] KindSample = 2'd0;
  localparam logic [1:0] KindDone   = 2'd1;
  localparam logic [1:0] KindError  = 2'd2;

  // Error codes.
  localparam logic [3:0] ErrNone     = 4'd0;
  localparam logic [3:0] ErrRiff     = 4'd1;
  localparam logic [3:0] ErrWave     = 4'd2;
  localparam logic [3:0] ErrFmt      = 4'd3;
  localparam logic [3:0] ErrPcm      = 4'd4;
  localparam logic [3:0] ErrChannels = 4'd5;
  localparam logic [3:0] ErrRate     = 4'd6;
  localparam logic [3:0] ErrBits     = 4'd7;
  localparam logic [3:0] ErrNoData   = 4'd8;
  localparam logic [3:0] ErrShort    = 4'd9;

  // Parse phases.
  localparam logic [3:0] PhRiff      = 4'd0;
  localparam logic [3:0] PhRiffSize  = 4'd1;
  localparam logic [3:0] PhWave      = 4'd2;
  localparam logic [3:0] PhFmtTag    = 4'd3;
  localparam logic [3:0] PhFmtSize   = 4'd4;
  localparam logic [3:0] PhFormat    = 4'd5;
  localparam logic [3:0] PhChannels  = 4'd6;
  localparam logic [3:0] PhRate      = 4'd7;
  localparam logic [3:0] PhByteRate  = 4'd8;
  localparam logic [3:0] PhBits      = 4'd9;
  localparam logic [3:0] PhExtra     = 4'd10;
  localparam logic [3:0] PhChunkId   = 4'd11;
  localparam logic [3:0] PhChunkSize = 4'd12;
  localparam logic [3:0] PhChunkSkip = 4'd13;
  localparam logic [3:0] PhData      = 4'd14;
  localparam logic [3:0] PhTrail     = 4'd15;

  // Chunk tags as little-endian words.
  localparam logic [31:0] TagRiff = 32'h4646_4952;
  localparam logic [31:0] TagWave = 32'h4556_4157;
  localparam logic [31:0] TagFmt  = 32'h2074_6D66;
  localparam logic [31:0] TagData = 32'h6174_6164;

  localparam logic [18:0] RateReset = 19'd16000;

  // Byte length of the header field read in a phase.
  function automatic logic [2:0] field_len(input logic [3:0] ph);
    logic [2:0] len;
    case (ph) inside
      PhFormat, PhChannels, PhBits: len = 3'd2;
      PhByteRate:                   len = 3'd6;
      default:                      len = 3'd4;
    endcase
    return len;
  endfunction

  // Error reported when the stream ends while in a header phase.
  function automatic logic [3:0] eos_code(input logic [3:0] ph);
    logic [3:0] code;
    case (ph) inside
      PhRiff:                   code = ErrRiff;
      PhRiffSize, PhWave:       code = ErrWave;
      PhFmtTag:                 code = ErrFmt;
      PhFmtSize, PhFormat:      code = ErrPcm;
      PhChannels:               code = ErrChannels;
      PhRate:                   code = ErrRate;
      PhByteRate, PhBits:       code = ErrBits;
      default:                  code = ErrNoData;
    endcase
    return code;
  endfunction

endpackage

// File: design/wpp_parser.sv
// Front part: parses one byte per accepted word and emits up to two results.
module wpp_parser (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  input  wpp_pkg::wpp_in_t   word_i,
  input  logic               cfg_we_i,
  input  logic [18:0]        cfg_wdata_i,
  output wpp_pkg::wpp_push_t push_o
);

  logic [18:0]        rate_q;
  logic [3:0]         phase_q, phase_d;
  logic [2:0]         seen_q, seen_d;
  logic [31:0]        shift_q, shift_d;
  logic [31:0]        remain_q, remain_d;
  logic [31:0]        extra_q, extra_d;
  logic               stereo_q, stereo_d;
  logic signed [15:0] held_q, held_d;
  logic               to_end_q, to_end_d;
  logic               failed_q, failed_d;
  logic               is_data_q, is_data_d;

  logic [7:0]         b;
  logic               eos;
  logic [1:0]         pos;
  logic [31:0]        remain_dec, extra_dec;
  logic [31:0]        shift_new;
  logic [2:0]         seen_inc;
  logic signed [15:0] v_sample;
  logic signed [16:0] pair_sum, pair_adj;
  logic               restart;
  logic               sample_v, final_v;
  logic signed [15:0] sample_val;
  logic [1:0]         final_kind;
  logic [3:0]         final_code;
  wpp_pkg::wpp_out_t  sample_r, final_r;

  assign b          = word_i.in_byte;
  assign eos        = word_i.end_of_stream;
  assign pos        = seen_q[1:0];
  assign remain_dec = remain_q - 32'd1;
  assign extra_dec  = extra_q - 32'd1;
  assign seen_inc   = seen_q + 3'd1;
  assign v_sample   = signed'({b, shift_q[7:0]});
  assign pair_sum   = {held_q[15], held_q} + {v_sample[15], v_sample};
  // Halving that truncates toward zero.
  assign pair_adj   = pair_sum + {16'd0, pair_sum[16]};
  // Byte placed into the little-endian field accumulator.
  assign shift_new  = (seen_q < 3'd4) ? (shift_q | ({24'd0, b} << {seen_q[1:0], 3'b000}))
                                      : shift_q;

  // Next-state and result logic for one byte.
  always_comb begin
    phase_d    = phase_q;
    seen_d     = seen_q;
    shift_d    = shift_q;
    remain_d   = remain_q;
    extra_d    = extra_q;
    stereo_d   = stereo_q;
    held_d     = held_q;
    to_end_d   = to_end_q;
    failed_d   = failed_q;
    is_data_d  = is_data_q;
    restart    = 1'b0;
    sample_v   = 1'b0;
    sample_val = '0;
    final_v    = 1'b0;
    final_kind = wpp_pkg::KindDone;
    final_code = wpp_pkg::ErrNone;

    if (failed_q) begin
      restart = eos;
    end else if (phase_q == wpp_pkg::PhTrail) begin
      if (eos) begin
        final_v = 1'b1;
        restart = 1'b1;
      end
    end else if (phase_q == wpp_pkg::PhData) begin
      if (!to_end_q) begin
        remain_d = remain_dec;
      end
      if (pos == 2'd0 || pos == 2'd2) begin
        shift_d = {24'd0, b};
        seen_d  = {1'b0, pos} + 3'd1;
      end else if (pos == 2'd3) begin
        sample_v   = 1'b1;
        sample_val = pair_adj[16:1];
        seen_d     = 3'd0;
      end else if (stereo_q) begin
        held_d = v_sample;
        seen_d = 3'd2;
      end else begin
        sample_v   = 1'b1;
        sample_val = v_sample;
        seen_d     = 3'd0;
      end
      if (!to_end_q && remain_dec == 32'd0) begin
        phase_d = wpp_pkg::PhTrail;
      end
      if (eos) begin
        final_v = 1'b1;
        restart = 1'b1;
        if (!(to_end_q || (!to_end_q && remain_dec == 32'd0))) begin
          final_kind = wpp_pkg::KindError;
          final_code = wpp_pkg::ErrShort;
        end
      end
    end else begin
      // Header and chunk walking.
      if (phase_q == wpp_pkg::PhExtra) begin
        extra_d = extra_dec;
        if (extra_dec == 32'd0) begin
          phase_d = wpp_pkg::PhChunkId;
        end
      end else if (phase_q == wpp_pkg::PhChunkSkip) begin
        remain_d = remain_dec;
        if (remain_dec == 32'd0) begin
          phase_d = wpp_pkg::PhChunkId;
        end
      end else begin
        shift_d = shift_new;
        seen_d  = seen_inc;
        if (seen_inc >= wpp_pkg::field_len(phase_q)) begin
          seen_d  = 3'd0;
          shift_d = '0;
          phase_d = phase_q + 4'd1;
          unique case (phase_q)
            wpp_pkg::PhRiff: begin
              if (shift_new != wpp_pkg::TagRiff) final_code = wpp_pkg::ErrRiff;
            end
            wpp_pkg::PhWave: begin
              if (shift_new != wpp_pkg::TagWave) final_code = wpp_pkg::ErrWave;
            end
            wpp_pkg::PhFmtTag: begin
              if (shift_new != wpp_pkg::TagFmt) final_code = wpp_pkg::ErrFmt;
            end
            wpp_pkg::PhFmtSize: begin
              extra_d = (shift_new > 32'd16) ? shift_new - 32'd16 : 32'd0;
            end
            wpp_pkg::PhFormat: begin
              if (shift_new[15:0] != 16'd1) final_code = wpp_pkg::ErrPcm;
            end
            wpp_pkg::PhChannels: begin
              if (shift_new[15:0] == 16'd1 || shift_new[15:0] == 16'd2) begin
                stereo_d = (shift_new[15:0] == 16'd2);
              end else begin
                final_code = wpp_pkg::ErrChannels;
              end
            end
            wpp_pkg::PhRate: begin
              if (shift_new != {13'd0, rate_q}) final_code = wpp_pkg::ErrRate;
            end
            wpp_pkg::PhBits: begin
              if (shift_new[15:0] != 16'd16) begin
                final_code = wpp_pkg::ErrBits;
              end
              phase_d = (extra_q != 32'd0) ? wpp_pkg::PhExtra : wpp_pkg::PhChunkId;
            end
            wpp_pkg::PhChunkId: begin
              is_data_d = (shift_new == wpp_pkg::TagData);
            end
            wpp_pkg::PhChunkSize: begin
              if (is_data_q) begin
                remain_d = shift_new;
                to_end_d = (shift_new == 32'd0);
                phase_d  = wpp_pkg::PhData;
              end else if (shift_new == 32'd0) begin
                phase_d = wpp_pkg::PhChunkId;
              end else begin
                remain_d = shift_new;
                phase_d  = wpp_pkg::PhChunkSkip;
              end
            end
            default: begin
              // Size fields that are only skipped over.
            end
          endcase
        end
      end

      if (final_code != wpp_pkg::ErrNone) begin
        // A failed header check reports once and waits for the stream end.
        final_v    = 1'b1;
        final_kind = wpp_pkg::KindError;
        restart    = eos;
        failed_d   = !eos;
      end else if (eos) begin
        final_v = 1'b1;
        restart = 1'b1;
        if (phase_d == wpp_pkg::PhData) begin
          if (!to_end_d) begin
            final_kind = wpp_pkg::KindError;
            final_code = wpp_pkg::ErrShort;
          end
        end else if (phase_d < wpp_pkg::PhData) begin
          final_kind = wpp_pkg::KindError;
          final_code = wpp_pkg::eos_code(phase_d);
        end
      end
    end

    // The stream end returns the parser to its start.
    if (restart) begin
      phase_d   = wpp_pkg::PhRiff;
      seen_d    = '0;
      shift_d   = '0;
      remain_d  = '0;
      extra_d   = '0;
      stereo_d  = 1'b0;
      held_d    = '0;
      to_end_d  = 1'b0;
      failed_d  = 1'b0;
      is_data_d = 1'b0;
    end
  end

  // Result words in stream order: a sample comes before the closing word.
  always_comb begin
    sample_r.sample     = sample_val;
    sample_r.kind       = wpp_pkg::KindSample;
    sample_r.error_code = wpp_pkg::ErrNone;
    sample_r.last       = 1'b0;
    final_r.sample      = '0;
    final_r.kind        = final_kind;
    final_r.error_code  = final_code;
    final_r.last        = 1'b1;
    push_o.first        = sample_v ? sample_r : final_r;
    push_o.second       = final_r;
    push_o.count        = valid_i ? ({1'b0, sample_v} + {1'b0, final_v}) : 2'd0;
  end

  // Configuration register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rate_q <= wpp_pkg::RateReset;
    end else if (cfg_we_i) begin
      rate_q <= cfg_wdata_i;
    end
  end

  // Parser state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= wpp_pkg::PhRiff;
      seen_q    <= '0;
      shift_q   <= '0;
      remain_q  <= '0;
      extra_q   <= '0;
      stereo_q  <= 1'b0;
      held_q    <= '0;
      to_end_q  <= 1'b0;
      failed_q  <= 1'b0;
      is_data_q <= 1'b0;
    end else if (valid_i) begin
      phase_q   <= phase_d;
      seen_q    <= seen_d;
      shift_q   <= shift_d;
      remain_q  <= remain_d;
      extra_q   <= extra_d;
      stereo_q  <= stereo_d;
      held_q    <= held_d;
      to_end_q  <= to_end_d;
      failed_q  <= failed_d;
      is_data_q <= is_data_d;
    end
  end

endmodule

// File: design/wpp_queue.sv
// Back part: result queue that takes up to two words a cycle and hands out one.
module wpp_queue #(
  parameter int Depth = 4
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  wpp_pkg::wpp_push_t push_i,
  output logic               full_o,
  output logic               empty_o,
  input  logic               pop_i,
  output wpp_pkg::wpp_out_t  head_o
);

  localparam int PtrW = $clog2(Depth);
  localparam int CntW = $clog2(Depth + 1);

  wpp_pkg::wpp_out_t mem_q [Depth];
  logic [PtrW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]   count_q, count_d;
  logic [PtrW-1:0]   wr_ptr_next;
  logic              do_pop;

  assign wr_ptr_next = wr_ptr_q + PtrW'(1);
  assign do_pop      = pop_i && !empty_o;
  assign empty_o     = (count_q == '0);
  // Room for a full pair of words is needed before a byte is taken.
  assign full_o      = (count_q > CntW'(Depth - 2));
  assign head_o      = mem_q[rd_ptr_q];

  // Pointer and fill bookkeeping.
  always_comb begin
    wr_ptr_d = wr_ptr_q + PtrW'(push_i.count);
    rd_ptr_d = do_pop ? rd_ptr_q + PtrW'(1) : rd_ptr_q;
    count_d  = count_q + CntW'(push_i.count) - CntW'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Word storage.
  always_ff @(posedge clk_i) begin
    if (push_i.count != 2'd0) begin
      mem_q[wr_ptr_q] <= push_i.first;
    end
    if (push_i.count == 2'd2) begin
      mem_q[wr_ptr_next] <= push_i.second;
    end
  end

endmodule

// File: design/wav_pcm_stream_parser.sv
// WAV PCM stream parser: 16-bit PCM file in, mono Q1.15 samples and status out.
// The block takes one file byte per cycle on the push side and never stalls
// on its own: full rises only when the result queue has fewer than two free
// entries (QueueDepth, a power of two, at least 4). Each byte yields zero, one
// or two result words, which appear on the pop side in the cycle after the byte
// is taken. Headers RIFF/WAVE/fmt are checked against PCM, 1 or 2 channels,
// the configured rate and 16 bits; stereo pairs are averaged toward zero. The
// last word of every stream carries last = 1 and is either done or an error.
// The rate register must be written only while the block is idle; the block itself does not enforce this.
`include "assert_macros.svh"

module wav_pcm_stream_parser #(
  parameter int QueueDepth = 4
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push,
  output logic              full,
  input  wpp_pkg::wpp_in_t  in_word_i,
  output logic              empty,
  input  logic              pop,
  output wpp_pkg::wpp_out_t result_o,
  input  logic              cfg_we_i,
  input  logic [18:0]       cfg_wdata_i
);

  wpp_pkg::wpp_push_t push_w;
  logic               accept;

  assign accept = push && !full;

  // Front: byte parser.
  wpp_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (accept),
    .word_i      (in_word_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .push_o      (push_w)
  );

  // Back: result queue.
  wpp_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push_w),
    .full_o  (full),
    .empty_o (empty),
    .pop_i   (pop),
    .head_o  (result_o)
  );

  // A sample word never closes a stream; a status word always does.
  `ASSERT_IMPLY(a_last_on_status, clk_i, rst_ni, !empty, ((result_o.kind == wpp_pkg::KindSample) != result_o.last), "last flag does not match word kind")

  // Only error words carry an error code.
  `ASSERT_IMPLY(a_code_on_error, clk_i, rst_ni, !empty, ((result_o.kind == wpp_pkg::KindError) == (result_o.error_code != wpp_pkg::ErrNone)), "error code does not match word kind")

  // Words appear only after a byte is taken.
  `ASSERT_NEXT(a_no_spurious_word, clk_i, rst_ni, (empty && !accept), empty, "result word appeared without an input byte")

endmodule

// File: dv/wav_pcm_stream_parser_tb.sv
`timescale 1ns / 100ps

// Testbench for the WAV PCM stream parser: directed and random files checked by a scoreboard.
module wav_pcm_stream_parser_tb;

  localparam int StallLimit = 3000;
  localparam int HoldCycles = 150;
  localparam int DrainCycles = 4;
  localparam logic [31:0] TagList = 32'h5453_494C;

  // Scoreboard: tracks the parser state and holds the result words still to come.
  class pcm_scoreboard;
    wpp_pkg::wpp_out_t expected_words[$];
    int                errors;
    logic [18:0]       rate_setting;
    logic [3:0]        hdr_phase;
    logic [2:0]        byte_count;
    logic [31:0]       shift_reg;
    logic [31:0]       bytes_left;
    logic [31:0]       fmt_skip;
    bit                is_stereo;
    int                left_sample;
    bit                run_to_end;
    bit                is_failed;
    bit                chunk_data;

    function new();
      errors = 0;
      rate_setting = wpp_pkg::RateReset;
      clear_parse();
    endfunction

    function void clear_parse();
      hdr_phase = wpp_pkg::PhRiff;
      byte_count = 3'd0;
      shift_reg = 32'd0;
      bytes_left = 32'd0;
      fmt_skip = 32'd0;
      is_stereo = 1'b0;
      left_sample = 0;
      run_to_end = 1'b0;
      is_failed = 1'b0;
      chunk_data = 1'b0;
    endfunction

    // Number of bytes in the header field read in a phase.
    function logic [2:0] hdr_len(logic [3:0] ph);
      logic [2:0] len;
      case (ph) inside
        wpp_pkg::PhFormat, wpp_pkg::PhChannels, wpp_pkg::PhBits: len = 3'd2;
        wpp_pkg::PhByteRate:                                      len = 3'd6;
        default:                                                  len = 3'd4;
      endcase
      return len;
    endfunction

    // Error given when the stream stops in a header phase.
    function logic [3:0] end_err(logic [3:0] ph);
      logic [3:0] code;
      case (ph) inside
        wpp_pkg::PhRiff:                         code = wpp_pkg::ErrRiff;
        wpp_pkg::PhRiffSize, wpp_pkg::PhWave:    code = wpp_pkg::ErrWave;
        wpp_pkg::PhFmtTag:                       code = wpp_pkg::ErrFmt;
        wpp_pkg::PhFmtSize, wpp_pkg::PhFormat:   code = wpp_pkg::ErrPcm;
        wpp_pkg::PhChannels:                     code = wpp_pkg::ErrChannels;
        wpp_pkg::PhRate:                         code = wpp_pkg::ErrRate;
        wpp_pkg::PhByteRate, wpp_pkg::PhBits:    code = wpp_pkg::ErrBits;
        default:                                 code = wpp_pkg::ErrNoData;
      endcase
      return code;
    endfunction

    function void push_word(logic [1:0] kind, logic [3:0] code, int sample);
      wpp_pkg::wpp_out_t w;
      w.sample = 16'(sample);
      w.kind = kind;
      w.error_code = code;
      w.last = (kind != wpp_pkg::KindSample);
      expected_words.push_back(w);
    endfunction

    // Acts on a completed header field and picks the next phase.
    function logic [3:0] finish_field(logic [3:0] ph, logic [31:0] v);
      logic [3:0] code;
      code = wpp_pkg::ErrNone;
      hdr_phase = ph + 4'd1;
      case (ph)
        wpp_pkg::PhRiff:    if (v != wpp_pkg::TagRiff) code = wpp_pkg::ErrRiff;
        wpp_pkg::PhWave:    if (v != wpp_pkg::TagWave) code = wpp_pkg::ErrWave;
        wpp_pkg::PhFmtTag:  if (v != wpp_pkg::TagFmt) code = wpp_pkg::ErrFmt;
        wpp_pkg::PhFmtSize: fmt_skip = (v > 32'd16) ? v - 32'd16 : 32'd0;
        wpp_pkg::PhFormat:  if (v[15:0] != 16'd1) code = wpp_pkg::ErrPcm;
        wpp_pkg::PhChannels: begin
          if (v[15:0] == 16'd0 || v[15:0] > 16'd2) code = wpp_pkg::ErrChannels;
          is_stereo = (v[15:0] == 16'd2);
        end
        wpp_pkg::PhRate:    if (v != {13'd0, rate_setting}) code = wpp_pkg::ErrRate;
        wpp_pkg::PhBits: begin
          if (v[15:0] != 16'd16) code = wpp_pkg::ErrBits;
          else hdr_phase = (fmt_skip != 32'd0) ? wpp_pkg::PhExtra : wpp_pkg::PhChunkId;
        end
        wpp_pkg::PhChunkId: chunk_data = (v == wpp_pkg::TagData);
        wpp_pkg::PhChunkSize: begin
          if (chunk_data) begin
            bytes_left = v;
            run_to_end = (v == 32'd0);
            hdr_phase = wpp_pkg::PhData;
          end else if (v == 32'd0) begin
            hdr_phase = wpp_pkg::PhChunkId;
          end else begin
            bytes_left = v;
            hdr_phase = wpp_pkg::PhChunkSkip;
          end
        end
        default: ;
      endcase
      return code;
    endfunction

    // Predicts the result words caused by one accepted input word.
    function void note_byte(wpp_pkg::wpp_in_t w);
      logic [7:0]  b;
      bit          eos;
      logic [1:0]  pos;
      logic [31:0] field_val;
      logic [3:0]  code;
      int          v;
      b = w.in_byte;
      eos = w.end_of_stream;
      code = wpp_pkg::ErrNone;
      if (is_failed) begin
        if (eos) clear_parse();
        return;
      end
      if (hdr_phase == wpp_pkg::PhTrail) begin
        if (eos) begin
          push_word(wpp_pkg::KindDone, wpp_pkg::ErrNone, 0);
          clear_parse();
        end
        return;
      end
      // Sample data: little-endian pairs, stereo averaged toward zero.
      if (hdr_phase == wpp_pkg::PhData) begin
        pos = byte_count[1:0];
        if (!run_to_end) bytes_left = bytes_left - 32'd1;
        if (pos == 2'd0 || pos == 2'd2) begin
          shift_reg = {24'd0, b};
          byte_count = {1'b0, pos} + 3'd1;
        end else begin
          v = $signed({b, shift_reg[7:0]});
          if (pos == 2'd3) begin
            push_word(wpp_pkg::KindSample, wpp_pkg::ErrNone, (left_sample + v) / 2);
            byte_count = 3'd0;
          end else if (is_stereo) begin
            left_sample = v;
            byte_count = 3'd2;
          end else begin
            push_word(wpp_pkg::KindSample, wpp_pkg::ErrNone, v);
            byte_count = 3'd0;
          end
        end
        if (!run_to_end && bytes_left == 32'd0) hdr_phase = wpp_pkg::PhTrail;
        if (eos) begin
          if (run_to_end || hdr_phase == wpp_pkg::PhTrail)
            push_word(wpp_pkg::KindDone, wpp_pkg::ErrNone, 0);
          else push_word(wpp_pkg::KindError, wpp_pkg::ErrShort, 0);
          clear_parse();
        end
        return;
      end
      // Header bytes: skipped bytes or little-endian fields.
      if (hdr_phase == wpp_pkg::PhExtra) begin
        fmt_skip = fmt_skip - 32'd1;
        if (fmt_skip == 32'd0) hdr_phase = wpp_pkg::PhChunkId;
      end else if (hdr_phase == wpp_pkg::PhChunkSkip) begin
        bytes_left = bytes_left - 32'd1;
        if (bytes_left == 32'd0) hdr_phase = wpp_pkg::PhChunkId;
      end else begin
        if (byte_count < 3'd4) shift_reg = shift_reg | (32'(b) << (8 * byte_count));
        byte_count = byte_count + 3'd1;
        if (byte_count >= hdr_len(hdr_phase)) begin
          field_val = shift_reg;
          byte_count = 3'd0;
          shift_reg = 32'd0;
          code = finish_field(hdr_phase, field_val);
        end
      end
      if (code != wpp_pkg::ErrNone) begin
        push_word(wpp_pkg::KindError, code, 0);
        if (eos) clear_parse();
        else is_failed = 1'b1;
        return;
      end
      if (eos) begin
        if (hdr_phase == wpp_pkg::PhData) begin
          if (run_to_end) push_word(wpp_pkg::KindDone, wpp_pkg::ErrNone, 0);
          else push_word(wpp_pkg::KindError, wpp_pkg::ErrShort, 0);
        end else if (hdr_phase < wpp_pkg::PhData) begin
          push_word(wpp_pkg::KindError, end_err(hdr_phase), 0);
        end else begin
          push_word(wpp_pkg::KindDone, wpp_pkg::ErrNone, 0);
        end
        clear_parse();
      end
    endfunction

    task report_mismatch(string what, int got, int want);
      $display("MISMATCH at %0t: %s is %0d, expected %0d", $time, what, got, want);
      errors++;
    endtask

    // Compares one accepted result word with the oldest expected one.
    task check_word(wpp_pkg::wpp_out_t got);
      wpp_pkg::wpp_out_t want;
      if (expected_words.size() == 0) begin
        report_mismatch("kind of a word with none expected", int'(got.kind), -1);
        return;
      end
      want = expected_words.pop_front();
      if (got.sample !== want.sample)
        report_mismatch("sample", int'(got.sample), int'(want.sample));
      if (got.kind !== want.kind)
        report_mismatch("kind", int'(got.kind), int'(want.kind));
      if (got.error_code !== want.error_code)
        report_mismatch("error_code", int'(got.error_code), int'(want.error_code));
      if (got.last !== want.last)
        report_mismatch("last", int'(got.last), int'(want.last));
    endtask
  endclass

  // Header fields of one generated file.
  typedef struct {
    logic [31:0] riff_tag, wave_tag, fmt_tag, fmt_size;
    logic [15:0] format, chans;
    logic [31:0] srate;
    logic [15:0] bits;
    int          n_skip;
    logic [31:0] skip_a, skip_b, data_size;
    int          data_len;
  } wav_hdr_t;

  logic              clk = 1'b0;
  logic              rst_ni = 1'b0;
  logic              push = 1'b0;
  logic              full;
  wpp_pkg::wpp_in_t  in_word_i = '0;
  logic              empty;
  logic              pop = 1'b0;
  wpp_pkg::wpp_out_t result_o;
  logic              cfg_we_i = 1'b0;
  logic [18:0]       cfg_wdata_i = '0;

  pcm_scoreboard sb;
  logic [7:0]    file_q[$];
  int            send_idle;
  int            recv_idle;
  bit            hold_request;

  wav_pcm_stream_parser dut (
    .clk_i      (clk),
    .rst_ni     (rst_ni),
    .push       (push),
    .full       (full),
    .in_word_i  (in_word_i),
    .empty      (empty),
    .pop        (pop),
    .result_o   (result_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  always #1 clk = ~clk;

  // File building helpers.
  function automatic logic [7:0] rand_byte();
    logic [7:0] b;
    case ($urandom_range(7))
      0:       b = 8'h00;
      1:       b = 8'hFF;
      2:       b = 8'h80;
      3:       b = 8'h7F;
      default: b = 8'($urandom_range(255));
    endcase
    return b;
  endfunction

  function automatic void put_le(logic [31:0] v, int n);
    for (int i = 0; i < n; i++) file_q.push_back(v[8*i +: 8]);
  endfunction

  function automatic void put_random(int n);
    for (int i = 0; i < n; i++) file_q.push_back(rand_byte());
  endfunction

  function automatic int capped(logic [31:0] v);
    return (v > 32'd8) ? 8 : int'(v);
  endfunction

  function automatic wav_hdr_t default_hdr();
    wav_hdr_t h;
    h.riff_tag = wpp_pkg::TagRiff;
    h.wave_tag = wpp_pkg::TagWave;
    h.fmt_tag = wpp_pkg::TagFmt;
    h.fmt_size = 32'd16;
    h.format = 16'd1;
    h.chans = 16'd1;
    h.srate = {13'd0, sb.rate_setting};
    h.bits = 16'd16;
    h.n_skip = 0;
    h.skip_a = 32'd0;
    h.skip_b = 32'd0;
    h.data_size = 32'd0;
    h.data_len = 0;
    return h;
  endfunction

  // Writes the header, any skipped chunks, the data chunk head and its random data bytes into the file.
  function automatic void build_file(wav_hdr_t h);
    file_q.delete();
    put_le(h.riff_tag, 4);
    put_le($urandom, 4);
    put_le(h.wave_tag, 4);
    put_le(h.fmt_tag, 4);
    put_le(h.fmt_size, 4);
    put_le(32'(h.format), 2);
    put_le(32'(h.chans), 2);
    put_le(h.srate, 4);
    put_le($urandom, 4);
    put_le($urandom, 2);
    put_le(32'(h.bits), 2);
    if (h.fmt_size > 32'd16) put_random(capped(h.fmt_size - 32'd16));
    if (h.n_skip > 0) begin
      put_le(TagList, 4);
      put_le(h.skip_a, 4);
      put_random(capped(h.skip_a));
    end
    if (h.n_skip > 1) begin
      put_le(TagList, 4);
      put_le(h.skip_b, 4);
      put_random(capped(h.skip_b));
    end
    put_le(wpp_pkg::TagData, 4);
    put_le(h.data_size, 4);
    put_random(h.data_len);
  endfunction

  function automatic wav_hdr_t random_hdr();
    wav_hdr_t h;
    h = default_hdr();
    h.chans = 16'($urandom_range(1, 2));
    case ($urandom_range(5)) inside
      0:       h.fmt_size = $urandom_range(0, 15);
      1, 2:    h.fmt_size = 32'd16;
      default: h.fmt_size = 32'd16 + $urandom_range(1, 3);
    endcase
    h.n_skip = ($urandom_range(2) == 0) ? $urandom_range(1, 2) : 0;
    h.skip_a = $urandom_range(0, 5);
    h.skip_b = $urandom_range(0, 5);
    if ($urandom_range(3) == 0) begin
      h.data_size = 32'd0;
      h.data_len = $urandom_range(0, 24);
    end else begin
      h.data_size = $urandom_range(1, 24);
      if ($urandom_range(4) == 0) h.data_len = $urandom_range(0, int'(h.data_size) - 1);
      else h.data_len = int'(h.data_size) + $urandom_range(0, 3);
    end
    return h;
  endfunction

  // Breaks one header field at random.
  function automatic void spoil_hdr(ref wav_hdr_t h);
    case ($urandom_range(10))
      0:  h.riff_tag ^= 32'd1 << $urandom_range(31);
      1:  h.wave_tag ^= 32'd1 << $urandom_range(31);
      2:  h.fmt_tag ^= 32'd1 << $urandom_range(31);
      3:  h.fmt_size = $urandom;
      4:  h.format = 16'($urandom_range(65535));
      5:  h.chans = 16'($urandom_range(0, 8));
      6:  h.srate = h.srate + $urandom_range(1, 3);
      7:  h.srate ^= 32'd1 << $urandom_range(31);
      8:  h.bits = 16'($urandom_range(0, 40));
      9: begin
        h.n_skip = 1;
        h.skip_a = $urandom;
      end
      default: h.data_size = $urandom;
    endcase
  endfunction

  // Offers one input word and waits until the block takes it.
  task automatic send_byte(logic [7:0] b, bit eos);
    wpp_pkg::wpp_in_t w;
    w.in_byte = b;
    w.end_of_stream = eos;
    in_word_i <= w;
    push <= 1'b1;
    do begin
      @(posedge clk);
    end while (full);
    sb.note_byte(w);
  endtask

  // Sends the first count bytes of the file, the last one marked as end of stream.
  task automatic send_file(int count);
    for (int i = 0; i < count; i++) begin
      while ($urandom_range(99) < send_idle) begin
        push <= 1'b0;
        @(posedge clk);
      end
      send_byte(file_q[i], i == count - 1);
    end
  endtask

  // Stops sending and lets every expected word drain out.
  task automatic wait_idle();
    push <= 1'b0;
    while (sb.expected_words.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic write_rate(logic [18:0] r);
    cfg_wdata_i <= r;
    cfg_we_i <= 1'b1;
    @(posedge clk);
    cfg_we_i <= 1'b0;
    sb.rate_setting = r;
  endtask

  task automatic run_directed();
    wav_hdr_t h;
    int       cut;
    // Stereo pairs averaged toward zero; the last byte gives a sample and done.
    h = default_hdr();
    h.chans = 16'd2;
    h.data_size = 32'd20;
    build_file(h);
    put_le(32'h8000, 2);
    put_le(32'h8000, 2);
    put_le(32'h7FFF, 2);
    put_le(32'h7FFF, 2);
    put_le(32'hFFFF, 2);
    put_le(32'h0000, 2);
    put_le(32'h0001, 2);
    put_le(32'h0000, 2);
    put_le(32'hFFFD, 2);
    put_le(32'h0000, 2);
    send_file(file_q.size());
    // Extra fmt bytes, two skipped chunks (one empty) and data to the end
    // with a lone trailing byte.
    h = default_hdr();
    h.fmt_size = 32'd18;
    h.n_skip = 2;
    h.skip_a = 32'd3;
    h.data_size = 32'd0;
    build_file(h);
    put_le(32'h1234, 2);
    put_le(32'hEDCB, 2);
    put_le(32'h55, 1);
    send_file(file_q.size());
    // An fmt size below the standard one, and data that ends before its size.
    h = default_hdr();
    h.fmt_size = 32'd10;
    h.data_size = 32'd10;
    build_file(h);
    put_random(6);
    send_file(file_q.size());
    // Each header check failing, with two bytes after the failing field.
    for (int k = 0; k < 7; k++) begin
      h = default_hdr();
      h.data_size = 32'd2;
      h.data_len = 2;
      case (k)
        0: begin
          h.riff_tag = 32'h5846_4952;
          cut = 6;
        end
        1: begin
          h.wave_tag = 32'h4556_4158;
          cut = 14;
        end
        2: begin
          h.fmt_tag = 32'h2074_6D67;
          cut = 18;
        end
        3: begin
          h.format = 16'd3;
          cut = 24;
        end
        4: begin
          h.chans = 16'd3;
          cut = 26;
        end
        5: begin
          h.srate = h.srate | (32'd1 << 20);
          cut = 30;
        end
        default: begin
          h.bits = 16'd8;
          cut = 38;
        end
      endcase
      build_file(h);
      send_file(cut);
    end
    // A failed check on the final byte, then a stream cut inside the header.
    h = default_hdr();
    h.riff_tag = 32'h5846_4952;
    build_file(h);
    send_file(4);
    h = default_hdr();
    build_file(h);
    send_file(20);
  endtask

  // Mono extremes and bytes past the declared data, sent under a long hold-off.
  task automatic run_hold_file();
    wav_hdr_t h;
    h = default_hdr();
    h.data_size = 32'd8;
    build_file(h);
    put_le(32'h8000, 2);
    put_le(32'h7FFF, 2);
    put_le(32'h0000, 2);
    put_le(32'hFFFF, 2);
    put_le(32'hA55A, 2);
    hold_request = 1'b1;
    send_file(file_q.size());
  endtask

  // Mostly well-formed files with random content, some broken, cut or noise.
  task automatic run_random(int budget);
    int       sent;
    int       r;
    int       cut;
    wav_hdr_t h;
    sent = 0;
    while (sent < budget) begin
      r = $urandom_range(99);
      h = random_hdr();
      if (r >= 65 && r < 80) spoil_hdr(h);
      build_file(h);
      if (r >= 92) begin
        file_q.delete();
        put_random($urandom_range(1, 12));
      end
      cut = file_q.size();
      if (r >= 80 && r < 92) cut = $urandom_range(1, file_q.size());
      send_file(cut);
      sent += cut;
    end
  endtask

  // Result side: random pops, and one long hold-off on request.
  initial begin
    int hold_count;
    hold_count = 0;
    forever begin
      @(posedge clk);
      if (rst_ni && pop && !empty) sb.check_word(result_o);
      if (hold_request) begin
        hold_request = 1'b0;
        hold_count = HoldCycles;
      end
      if (!rst_ni) begin
        pop <= 1'b0;
      end else if (hold_count > 0) begin
        hold_count--;
        pop <= 1'b0;
      end else begin
        pop <= ($urandom_range(99) >= recv_idle);
      end
    end
  end

  // Watchdog: ends the run when no word moves for too long.
  initial begin
    int stall;
    stall = 0;
    while (stall < StallLimit) begin
      @(posedge clk);
      if (!rst_ni || (push && !full) || (pop && !empty)) stall = 0;
      else stall++;
    end
    $display("DONE: errors detected");
    $finish;
  end

  // Main sequence: reset, directed files, then random files in three idle phases.
  initial begin
    sb = new();
    send_idle = 16;
    recv_idle = 52;
    hold_request = 1'b0;
    repeat (10) @(posedge clk);
    rst_ni <= 1'b1;
    @(posedge clk);
    run_directed();
    wait_idle();
    write_rate(19'd1);
    run_random(40);
    wait_idle();
    send_idle = 52;
    recv_idle = 16;
    write_rate(19'd384000);
    run_random(40);
    wait_idle();
    send_idle = 0;
    recv_idle = 0;
    write_rate(19'($urandom_range(2, 383999)));
    run_hold_file();
    run_random(1);
    wait_idle();
    if (sb.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// File: filelist.f
+incdir+design
design/wpp_pkg.sv
design/wpp_parser.sv
design/wpp_queue.sv
design/wav_pcm_stream_parser.sv
dv/wav_pcm_stream_parser_tb.sv
